@@ sv/cpd_pkg.sv @@
// ----------------------------------------------------------------------------
// cpd_pkg
// types, register map and lookup functions for the charlieplexed 188 driver
// ----------------------------------------------------------------------------
package cpd_pkg;

	// command codes of an input request
	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_WAKE = 2'd1,
		CMD_FULL = 2'd2,
		CMD_OFF  = 2'd3
	} cmd_t;

	// register indexes (byte address is four times the index)
	localparam logic [1:0] REG_OFF_DELAY   = 2'd0;
	localparam logic [1:0] REG_TOGGLE      = 2'd1;
	localparam logic [1:0] REG_FULL_STEPS  = 2'd2;
	localparam logic [1:0] REG_SAMPLE_TICK = 2'd3;

	localparam int unsigned NUM_PINS = 5;
	localparam logic [8:0]  NO_VALUE = 9'd511;
	localparam logic [7:0]  MAX_PERCENT = 8'd100;
	localparam logic [7:0]  RESET_VALUE = 8'd188;
	localparam logic [2:0]  LAST_PHASE = 3'd4;

	// five cathode masks, one per anode pin, element 0 first
	typedef logic [4:0][3:0] mask_set_t;

	// cathode masks of the tens digit
	function automatic mask_set_t tens_row(input logic [3:0] d);
		unique case (d)
			4'd0: return {4'd8,  4'd15, 4'd1, 4'd0, 4'd0};
			4'd1: return {4'd8,  4'd1,  4'd0, 4'd0, 4'd0};
			4'd2: return {4'd4,  4'd11, 4'd1, 4'd0, 4'd0};
			4'd3: return {4'd12, 4'd11, 4'd0, 4'd0, 4'd0};
			4'd4: return {4'd12, 4'd5,  4'd0, 4'd0, 4'd0};
			4'd5: return {4'd12, 4'd14, 4'd0, 4'd0, 4'd0};
			4'd6: return {4'd12, 4'd14, 4'd1, 4'd0, 4'd0};
			4'd7: return {4'd8,  4'd3,  4'd0, 4'd0, 4'd0};
			4'd8: return {4'd12, 4'd15, 4'd1, 4'd0, 4'd0};
			4'd9: return {4'd12, 4'd15, 4'd0, 4'd0, 4'd0};
			default: return '0;
		endcase
	endfunction

	// cathode masks of the units digit
	function automatic mask_set_t units_row(input logic [3:0] d);
		unique case (d)
			4'd0: return {4'd0, 4'd0, 4'd2, 4'd7, 4'd3};
			4'd1: return {4'd0, 4'd0, 4'd2, 4'd4, 4'd0};
			4'd2: return {4'd0, 4'd0, 4'd4, 4'd6, 4'd3};
			4'd3: return {4'd0, 4'd0, 4'd6, 4'd6, 4'd1};
			4'd4: return {4'd0, 4'd0, 4'd6, 4'd5, 4'd0};
			4'd5: return {4'd0, 4'd0, 4'd6, 4'd3, 4'd1};
			4'd6: return {4'd0, 4'd0, 4'd6, 4'd3, 4'd3};
			4'd7: return {4'd0, 4'd0, 4'd2, 4'd6, 4'd0};
			4'd8: return {4'd0, 4'd0, 4'd6, 4'd7, 4'd3};
			4'd9: return {4'd0, 4'd0, 4'd6, 4'd7, 4'd1};
			default: return '0;
		endcase
	endfunction

	// pin pulled low for cathode bit b while anode p is scanned
	function automatic logic [2:0] cath_pin(input logic [2:0] p, input logic [1:0] b);
		logic [3:0][2:0] row;
		unique case (p)
			3'd0:    row = {3'd0, 3'd0, 3'd4, 3'd3};
			3'd1:    row = {3'd0, 3'd4, 3'd3, 3'd2};
			3'd2:    row = {3'd0, 3'd4, 3'd3, 3'd1};
			3'd3:    row = {3'd4, 3'd2, 3'd1, 3'd0};
			default: row = {3'd3, 3'd2, 3'd1, 3'd0};
		endcase
		return row[b];
	endfunction

	// decimal split by reciprocal multiply, exact below 1029
	function automatic mask_set_t build_masks(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  q;
		logic [4:0]  tens;
		logic [7:0]  units;
		mask_set_t   m;
		prod  = 16'(v) * 16'd205;
		q     = prod[15:11];
		if (q >= 5'd20) begin
			tens = q - 5'd20;
		end else if (q >= 5'd10) begin
			tens = q - 5'd10;
		end else begin
			tens = q;
		end
		units = v - 8'(q) * 8'd10;
		m = tens_row(tens[3:0]) | units_row(units[3:0]);
		if (v >= MAX_PERCENT) begin
			m[4] = m[4] | 4'd3;
		end
		return m;
	endfunction

endpackage

@@ sv/cpd_in_if.sv @@
// ----------------------------------------------------------------------------
// cpd_in_if
// input request channel: command, charger flag and battery percent
// ----------------------------------------------------------------------------
interface cpd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic       charger_present;
	logic [7:0] battery_level;

	modport source (output valid, output command, output charger_present,
		output battery_level, input ready);
	modport sink (input valid, input command, input charger_present,
		input battery_level, output ready);
endinterface

@@ sv/cpd_out_if.sv @@
// ----------------------------------------------------------------------------
// cpd_out_if
// result channel: pin drive pattern, display flag and shown value
// ----------------------------------------------------------------------------
interface cpd_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] pin_drive_enable;
	logic [4:0] pin_high;
	logic       display_active;
	logic [7:0] shown_value;

	modport source (output valid, output pin_drive_enable, output pin_high,
		output display_active, output shown_value, input ready);
	modport sink (input valid, input pin_drive_enable, input pin_high,
		input display_active, input shown_value, output ready);
endinterface

@@ sv/charlieplex_188_display_driver.sv @@
// ----------------------------------------------------------------------------
// charlieplex_188_display_driver
// 1 ms tick engine for a five pin charlieplexed "188" led display
// ----------------------------------------------------------------------------
// Every request on in_ch yields exactly one result on out_ch. A request's
// state update (tick and 5 ms prescaler, off delay, charge-full hold,
// cathode mask rebuild, anode scan and charger blink) is done by one pass
// of logic from the state registers into the result register, so one
// request per clock is accepted and its result appears in the next cycle.
// in_ch stays ready while the result register is empty or being
// drained, so the sustained rate is one request per cycle. Pins are reported
// as drive enable plus level: enabled and high is the scanned anode, enabled
// and low a lit cathode, disabled is high-Z. Registers sit on the APB port at
// byte addresses 0x0 off delay steps, 0x4 charge toggle ticks, 0x8 charge
// full steps and 0xC sample tick, and should be written only while idle.
module charlieplex_188_display_driver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	cpd_in_if.sink      in_ch,
	cpd_out_if.source   out_ch
);
	import cpd_pkg::*;

	// configuration registers
	logic [15:0] off_delay_q;
	logic [14:0] toggle_q;
	logic [15:0] full_steps_q;
	logic [15:0] sample_tick_q;

	// engine state
	logic [15:0] tick_q, tick_n;
	logic [2:0]  step_q, step_n;
	logic [15:0] off_cnt_q, off_cnt_n;
	logic [15:0] hold_q, hold_n;
	logic        full_q, full_n;
	logic        on_q, on_n;
	logic [2:0]  scan_q, scan_n;
	logic [7:0]  target_q, target_n;
	logic [8:0]  built_q, built_n;
	mask_set_t   masks_q, masks_n;

	// scan and blink helpers
	logic [4:0]  en_n, hi_n;
	logic [2:0]  phase;
	logic [3:0]  cur_mask;
	logic [15:0] tog2;
	logic        toggle;

	// result register
	logic        out_valid_q;
	logic [4:0]  out_en_q, out_hi_q;
	logic        out_on_q;
	logic [7:0]  out_value_q;

	logic        accept;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// result register frees up as soon as the sink takes it
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign out_ch.valid            = out_valid_q;
	assign out_ch.pin_drive_enable = out_en_q;
	assign out_ch.pin_high         = out_hi_q;
	assign out_ch.display_active   = out_on_q;
	assign out_ch.shown_value      = out_value_q;

	// register write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_delay_q   <= 16'd1000;
			toggle_q      <= 15'd500;
			full_steps_q  <= 16'd2000;
			sample_tick_q <= 16'd1000;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_OFF_DELAY:   off_delay_q   <= pwdata[15:0];
				REG_TOGGLE:      toggle_q      <= pwdata[14:0];
				REG_FULL_STEPS:  full_steps_q  <= pwdata[15:0];
				REG_SAMPLE_TICK: sample_tick_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read port
	always_comb begin
		unique case (paddr[3:2])
			REG_OFF_DELAY:   prdata = {16'd0, off_delay_q};
			REG_TOGGLE:      prdata = {17'd0, toggle_q};
			REG_FULL_STEPS:  prdata = {16'd0, full_steps_q};
			REG_SAMPLE_TICK: prdata = {16'd0, sample_tick_q};
			default:         prdata = '0;
		endcase
	end

	// next state and pin pattern for the request on in_ch
	always_comb begin
		tick_n    = tick_q;
		step_n    = step_q;
		off_cnt_n = off_cnt_q;
		hold_n    = hold_q;
		full_n    = full_q;
		on_n      = on_q;
		scan_n    = scan_q;
		target_n  = target_q;
		built_n   = built_q;
		masks_n   = masks_q;
		en_n      = '0;
		hi_n      = '0;
		phase     = '0;
		cur_mask  = '0;
		tog2      = {toggle_q, 1'b0};
		toggle    = 1'b0;

		unique case (cmd_t'(in_ch.command))
			CMD_TICK: begin
				tick_n = tick_q + 16'd1;
				step_n = (step_q >= LAST_PHASE) ? 3'd0 : step_q + 3'd1;

				// 5 ms step
				if (step_n == 3'd0) begin
					if (off_cnt_n != 16'hFFFF) begin
						off_cnt_n = off_cnt_n + 16'd1;
					end
					// rebuild masks only when the shown value changed
					if (on_n && built_q != {1'b0, target_q}) begin
						built_n = {1'b0, target_q};
						masks_n = build_masks(target_q);
					end
					// charge-full hold runs out
					if (hold_q != 16'd0) begin
						hold_n = hold_q - 16'd1;
						if (hold_n == 16'd0) begin
							off_cnt_n = '0;
							on_n      = 1'b0;
							built_n   = NO_VALUE;
						end
					end
					// auto-off, not while charging
					if (!in_ch.charger_present && off_cnt_n == off_delay_q) begin
						off_cnt_n = '0;
						on_n      = 1'b0;
						built_n   = NO_VALUE;
					end
				end

				// battery sample, clamped to full scale
				if (tick_n == sample_tick_q) begin
					target_n = (in_ch.battery_level > MAX_PERCENT) ?
						MAX_PERCENT : in_ch.battery_level;
					if (!in_ch.charger_present) begin
						tick_n = '0;
						step_n = '0;
					end
				end

				// scan one anode; an out of range phase counts as the last one
				if (on_n) begin
					phase    = (scan_q > LAST_PHASE) ? LAST_PHASE : scan_q;
					cur_mask = masks_n[phase];
					if (cur_mask != 4'd0) begin
						en_n = 5'd1 << phase;
						hi_n = 5'd1 << phase;
						for (int b = 0; b < 4; b++) begin
							if (cur_mask[b]) begin
								en_n = en_n | (5'd1 << cath_pin(phase, 2'(b)));
							end
						end
					end
					scan_n = (phase == LAST_PHASE) ? 3'd0 : phase + 3'd1;
				end

				// blink while the charger is present
				if (in_ch.charger_present) begin
					if (tick_n == {1'b0, toggle_q}) begin
						toggle = 1'b1;
					end else if (tick_n == tog2) begin
						toggle = 1'b1;
						tick_n = '0;
						step_n = '0;
					end else if (tick_n > tog2) begin
						tick_n = '0;
						step_n = '0;
					end
					if (toggle) begin
						if (full_q) begin
							// after charge full the blink can only turn it back on
							if (!on_n && hold_n != 16'd0) begin
								off_cnt_n = '0;
								on_n      = 1'b1;
							end
						end else if (on_n) begin
							off_cnt_n = '0;
							on_n      = 1'b0;
							built_n   = NO_VALUE;
							en_n      = '0;
							hi_n      = '0;
						end else begin
							off_cnt_n = '0;
							on_n      = 1'b1;
						end
					end
				end
			end
			CMD_WAKE: begin
				off_cnt_n = '0;
				on_n      = 1'b1;
			end
			CMD_FULL: begin
				full_n = 1'b1;
				hold_n = full_steps_q;
			end
			CMD_OFF: begin
				off_cnt_n = '0;
				on_n      = 1'b0;
				built_n   = NO_VALUE;
			end
			default: ;
		endcase
	end

	// state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			step_q    <= '0;
			off_cnt_q <= '0;
			hold_q    <= '0;
			full_q    <= 1'b0;
			on_q      <= 1'b1;
			scan_q    <= '0;
			target_q  <= RESET_VALUE;
			built_q   <= '0;
			masks_q   <= '0;
		end else if (accept) begin
			tick_q    <= tick_n;
			step_q    <= step_n;
			off_cnt_q <= off_cnt_n;
			hold_q    <= hold_n;
			full_q    <= full_n;
			on_q      <= on_n;
			scan_q    <= scan_n;
			target_q  <= target_n;
			built_q   <= built_n;
			masks_q   <= masks_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_en_q    <= en_n;
			out_hi_q    <= hi_n;
			out_on_q    <= on_n;
			out_value_q <= target_n;
		end
	end

`ifndef NO_ASSERTIONS
	// at most one anode is driven high
	a_one_anode: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> $onehot0(out_ch.pin_high))
		else $error("more than one anode high");

	// a high pin is always a driven pin
	a_high_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.pin_high & ~out_ch.pin_drive_enable) == 5'd0)
		else $error("high pin not driven");

	// a dark display releases every pin
	a_dark_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.display_active |-> out_ch.pin_drive_enable == 5'd0)
		else $error("pins driven while display off");

	// shown value never exceeds what the display can show
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.shown_value <= RESET_VALUE)
		else $error("shown value out of range");

	// prescaler and scan phase stay in range
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> step_q <= LAST_PHASE && scan_q <= LAST_PHASE)
		else $error("phase counter out of range");
`endif

endmodule

@@ verif/charlieplex_pin_check.sv @@
// ----------------------------------------------------------------------------
// charlieplex_pin_check
// watches the register port and the request and result channels of the 188 display
// driver, predicts the pin pattern of every accepted request and compares
// each result with the oldest prediction still due
// ----------------------------------------------------------------------------
module charlieplex_pin_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	cpd_in_if           in_ch,
	cpd_out_if          out_ch,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import cpd_pkg::*;

	typedef struct packed {
		logic [4:0] drive;
		logic [4:0] level;
		logic       active;
		logic [7:0] value;
	} pin_frame_t;

	// segment masks per anode for each decimal digit, anode 0 first
	localparam logic [3:0] TENS_SEG [10][5] = '{
		'{0, 0, 1, 15, 8}, '{0, 0, 0, 1, 8}, '{0, 0, 1, 11, 4}, '{0, 0, 0, 11, 12},
		'{0, 0, 0, 5, 12}, '{0, 0, 0, 14, 12}, '{0, 0, 1, 14, 12}, '{0, 0, 0, 3, 8},
		'{0, 0, 1, 15, 12}, '{0, 0, 0, 15, 12}
	};
	localparam logic [3:0] UNITS_SEG [10][5] = '{
		'{3, 7, 2, 0, 0}, '{0, 4, 2, 0, 0}, '{3, 6, 4, 0, 0}, '{1, 6, 6, 0, 0},
		'{0, 5, 6, 0, 0}, '{1, 3, 6, 0, 0}, '{3, 3, 6, 0, 0}, '{0, 6, 2, 0, 0},
		'{3, 7, 6, 0, 0}, '{1, 7, 6, 0, 0}
	};
	// pin pulled low by each mask bit while a given anode is scanned
	localparam logic [2:0] CATHODE_OF [5][4] = '{
		'{3, 4, 0, 0}, '{2, 3, 4, 0}, '{1, 3, 4, 0}, '{0, 1, 2, 4}, '{0, 1, 2, 3}
	};

	logic [15:0] cfg_off_delay, cfg_full_steps, cfg_sample;
	logic [14:0] cfg_toggle;

	logic [15:0] ticks, off_cnt, hold_cnt;
	logic [2:0]  prescale, anode;
	logic        full_flag, lit;
	logic [7:0]  value;
	logic [8:0]  built;
	logic [3:0]  masks [5];
	logic [4:0]  pin_drive, pin_level;

	pin_frame_t frames_due [$];

	task automatic blank_display();
		off_cnt = '0;
		lit = 1'b0;
		built = NO_VALUE;
		pin_drive = '0;
		pin_level = '0;
	endtask

	task automatic wake_display();
		off_cnt = '0;
		lit = 1'b1;
	endtask

	task automatic clear_ticks();
		ticks = '0;
		prescale = '0;
	endtask

	task automatic load_digits(input logic [7:0] v);
		int t;
		int u;
		t = (int'(v) / 10) % 10;
		u = int'(v) % 10;
		for (int i = 0; i < 5; i++) masks[i] = TENS_SEG[t][i] | UNITS_SEG[u][i];
		if (v >= MAX_PERCENT) masks[4] = masks[4] | 4'd3;
	endtask

	// charger blink: once charge-full was seen it can only relight the display
	task automatic blink();
		if (full_flag) begin
			if (!lit && hold_cnt != 0) wake_display();
		end else if (lit) begin
			blank_display();
		end else begin
			wake_display();
		end
	endtask

	task automatic scan_anode();
		logic [2:0] p;
		logic [3:0] m;
		p = (anode > LAST_PHASE) ? LAST_PHASE : anode;
		m = masks[p];
		pin_drive = '0;
		pin_level = '0;
		if (m != '0) begin
			pin_drive = 5'd1 << p;
			pin_level = 5'd1 << p;
			for (int b = 0; b < 4; b++)
				if (m[b]) pin_drive = pin_drive | (5'd1 << CATHODE_OF[p][b]);
		end
		anode = (p == LAST_PHASE) ? 3'd0 : p + 3'd1;
	endtask

	task automatic run_tick(input logic chg, input logic [7:0] lvl);
		int twice;
		twice = 2 * int'(cfg_toggle);
		ticks = ticks + 16'd1;
		prescale = (prescale >= LAST_PHASE) ? 3'd0 : prescale + 3'd1;
		// 5 ms step
		if (prescale == 3'd0) begin
			if (off_cnt != 16'hFFFF) off_cnt = off_cnt + 16'd1;
			if (lit && built != {1'b0, value}) begin
				built = {1'b0, value};
				load_digits(value);
			end
			if (hold_cnt != '0) begin
				hold_cnt = hold_cnt - 16'd1;
				if (hold_cnt == '0) blank_display();
			end
			if (!chg && off_cnt == cfg_off_delay) blank_display();
		end
		if (ticks == cfg_sample) begin
			value = (lvl > MAX_PERCENT) ? MAX_PERCENT : lvl;
			if (!chg) clear_ticks();
		end
		pin_drive = '0;
		pin_level = '0;
		if (lit) scan_anode();
		if (chg) begin
			if (int'(ticks) == int'(cfg_toggle)) begin
				blink();
			end else if (int'(ticks) == twice) begin
				blink();
				clear_ticks();
			end else if (int'(ticks) > twice) begin
				clear_ticks();
			end
		end
	endtask

	task automatic predict_request(input cmd_t c, input logic chg, input logic [7:0] lvl,
		output pin_frame_t f);
		pin_drive = '0;
		pin_level = '0;
		case (c)
			CMD_TICK: run_tick(chg, lvl);
			CMD_WAKE: wake_display();
			CMD_FULL: begin
				full_flag = 1'b1;
				hold_cnt = cfg_full_steps;
			end
			default: blank_display();
		endcase
		f.drive = pin_drive;
		f.level = pin_level;
		f.active = lit;
		f.value = value;
	endtask

	task automatic compare_frame(input pin_frame_t want);
		if (out_ch.pin_drive_enable !== want.drive) begin
			$error("pin_drive_enable: expected %b, got %b", want.drive, out_ch.pin_drive_enable);
			errors++;
		end
		if (out_ch.pin_high !== want.level) begin
			$error("pin_high: expected %b, got %b", want.level, out_ch.pin_high);
			errors++;
		end
		if (out_ch.display_active !== want.active) begin
			$error("display_active: expected %b, got %b", want.active, out_ch.display_active);
			errors++;
		end
		if (out_ch.shown_value !== want.value) begin
			$error("shown_value: expected %0d, got %0d", want.value, out_ch.shown_value);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pin_frame_t f;
		if (!arst_n) begin
			cfg_off_delay = 16'd1000;
			cfg_toggle = 15'd500;
			cfg_full_steps = 16'd2000;
			cfg_sample = 16'd1000;
			ticks = '0;
			prescale = '0;
			off_cnt = '0;
			hold_cnt = '0;
			full_flag = 1'b0;
			lit = 1'b1;
			anode = '0;
			value = RESET_VALUE;
			built = '0;
			foreach (masks[i]) masks[i] = '0;
			frames_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_OFF_DELAY:  cfg_off_delay = pwdata[15:0];
					REG_TOGGLE:     cfg_toggle = pwdata[14:0];
					REG_FULL_STEPS: cfg_full_steps = pwdata[15:0];
					default:        cfg_sample = pwdata[15:0];
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_request(cmd_t'(in_ch.command), in_ch.charger_present,
					in_ch.battery_level, f);
				frames_due.push_back(f);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (frames_due.size() == 0) begin
					$error("result arrived with no request outstanding");
					errors++;
				end else begin
					compare_frame(frames_due.pop_front());
				end
			end
			pending = frames_due.size();
		end
	end

endmodule

@@ verif/tb_charlieplex_188_display_driver.sv @@
// ----------------------------------------------------------------------------
// tb_charlieplex_188_display_driver
// drives tick and command requests with random gaps and back-pressure,
// reprograms all four configuration registers between phases, and reports the
// verdict from the pin pattern checker running beside the driver
// ----------------------------------------------------------------------------
module tb_charlieplex_188_display_driver;
	timeunit 1ns;
	timeprecision 1ps;

	import cpd_pkg::*;

	// cycles with no handshake on either channel before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// length of the one long receiver hold-off
	localparam int HOLD_OFF_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	int errors, pending;
	int sent_count = 0;
	int reg_writes = 0;
	int settings = 1;
	int cmd_count [4] = '{0, 0, 0, 0};
	bit quiet = 1'b0;
	bit on_charger = 1'b0;
	bit held_off = 1'b0;

	cpd_in_if  in_ch ();
	cpd_out_if out_ch ();

	charlieplex_188_display_driver dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	charlieplex_pin_check pin_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (errors),
		.pending (pending)
	);

	// 20 ns clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// one request per call; random idle cycles in front unless quiet
	// valid stays high into the next call so back-to-back requests need no gap
	task automatic send_request(input cmd_t c, input logic chg, input logic [7:0] lvl);
		while (!quiet && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= c;
		in_ch.charger_present <= chg;
		in_ch.battery_level <= lvl;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		sent_count++;
		cmd_count[c]++;
	endtask

	// drain: drop valid and wait until every result has come back
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// leave a little margin after the last result comes back
		repeat (3) @(negedge clk);
	endtask

	// setup cycle then access cycle; the write lands on the edge with pready
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		reg_writes++;
	endtask

	task automatic apply_setting(input logic [15:0] off_steps, input logic [14:0] toggle,
		input logic [15:0] full_steps, input logic [15:0] sample);
		settle();
		write_reg(REG_OFF_DELAY, {16'd0, off_steps});
		write_reg(REG_TOGGLE, {17'd0, toggle});
		write_reg(REG_FULL_STEPS, {16'd0, full_steps});
		write_reg(REG_SAMPLE_TICK, {16'd0, sample});
		settings++;
	endtask

	// battery level leaning on the clamp boundary and the field extremes
	function automatic logic [7:0] pick_level();
		case ($urandom_range(9))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return MAX_PERCENT;
			3:       return MAX_PERCENT + 8'd1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly ticks so the counters get deep; commands are the noise
	function automatic cmd_t pick_command(input bit with_full);
		int r;
		r = $urandom_range(99);
		if (r < 82) return CMD_TICK;
		if (r < 90) return CMD_WAKE;
		if (!with_full || r < 95) return CMD_OFF;
		return CMD_FULL;
	endfunction

	// charger plugged and unplugged in runs so the blink counter gets a chance
	task automatic random_phase(input int n, input bit with_full);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 6) on_charger = !on_charger;
			send_request(pick_command(with_full), on_charger, pick_level());
		end
	endtask

	// result side: random stalls, plus one long hold-off that fills the block
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && sent_count >= 300) begin
				held_off = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				out_ch.ready <= quiet || ($urandom_range(99) >= 21);
			end
		end
	end

	// watchdog: nothing moving on either channel for too long ends the run
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
			else idle++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_TICK;
		in_ch.charger_present = 1'b0;
		in_ch.battery_level = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: masks are still empty, so the first scans drive nothing
		repeat (4) send_request(CMD_TICK, 1'b0, 8'd0);
		// fifth tick is the first 5 ms step and builds the "188" masks
		send_request(CMD_TICK, 1'b0, 8'd255);
		repeat (4) send_request(CMD_TICK, 1'b0, 8'd0);
		// off releases the pins, a tick while dark scans nothing, wake relights
		send_request(CMD_OFF, 1'b0, 8'd0);
		send_request(CMD_TICK, 1'b0, 8'd0);
		send_request(CMD_WAKE, 1'b1, 8'd255);
		send_request(CMD_TICK, 1'b0, 8'd0);

		// smallest delay and blink settings, short sample tick
		apply_setting(16'd1, 15'd1, 16'd2000, 16'd5);
		// tick count is past twice the blink period, so the charger clears it
		send_request(CMD_TICK, 1'b1, 8'd101);
		// blink off clears the pins the scan just drove, then blink back on
		send_request(CMD_TICK, 1'b1, 8'd0);
		send_request(CMD_TICK, 1'b1, 8'd0);
		// unplugged: sample tick clamps 255 to 100 and the off delay of one fires
		repeat (4) send_request(CMD_TICK, 1'b0, 8'd100);
		send_request(CMD_TICK, 1'b0, 8'd255);

		// largest register values, blink without charge-full
		apply_setting(16'd65535, 15'd32767, 16'd65535, 16'd65535);
		random_phase(40, 1'b0);
		for (int k = 0; k < 4; k++) begin
			apply_setting(16'($urandom_range(8, 1)), 15'($urandom_range(12, 1)),
				16'($urandom_range(10, 1)), 16'($urandom_range(40, 5)));
			random_phase(160, 1'b0);
		end

		// charge full sticks until reset, so it comes only after the plain blink runs
		apply_setting(16'd3, 15'd1, 16'd1, 16'd5);
		send_request(CMD_FULL, 1'b0, 8'd0);
		send_request(CMD_TICK, 1'b1, 8'd50);
		send_request(CMD_TICK, 1'b1, 8'd50);
		for (int k = 0; k < 4; k++) begin
			apply_setting(16'($urandom_range(8, 1)), 15'($urandom_range(12, 1)),
				16'($urandom_range(10, 1)), 16'($urandom_range(40, 5)));
			random_phase(160, 1'b1);
		end

		// long run without idling on either side, charger on and then off
		quiet = 1'b1;
		apply_setting(16'd4, 15'd3, 16'd2, 16'd7);
		repeat (30) send_request(CMD_TICK, 1'b1, pick_level());
		repeat (30) send_request(CMD_TICK, 1'b0, pick_level());
		quiet = 1'b0;

		settle();
		repeat (5) @(negedge clk);

		$display("covered %0d requests: %0d ticks, %0d wakes, %0d charge-full, %0d off",
			sent_count, cmd_count[CMD_TICK], cmd_count[CMD_WAKE], cmd_count[CMD_FULL],
			cmd_count[CMD_OFF]);
		$display("%0d register writes over %0d settings, with blink, hold and a gapless run",
			reg_writes, settings);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/cpd_pkg.sv
sv/cpd_in_if.sv
sv/cpd_out_if.sv
sv/charlieplex_188_display_driver.sv
verif/charlieplex_pin_check.sv
verif/tb_charlieplex_188_display_driver.sv
